// ===== rtl/core/cmop_pkg.sv =====
`timescale 1ns / 1ps
// package for the cross modulated oscillator pair
// holds codes, defaults and the length clamp; depends on nothing
package cmop_pkg;

  localparam int unsigned TableMaxDef   = 4096;
  localparam int unsigned SampleBitsDef = 16;
  localparam int unsigned CfgIdxW       = 3;
  localparam int unsigned CfgDataW      = 32;
  localparam int unsigned LenW          = 13;
  localparam int unsigned MulAW         = 35;
  localparam logic [31:0] InvTwoPi      = 32'd683565276;

  typedef enum logic [CfgIdxW-1:0] {
    CfgModMode  = 3'd0,
    CfgInterp   = 3'd1,
    CfgBaseInc  = 3'd2,
    CfgLenOne   = 3'd3,
    CfgLenTwo   = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ModeSample = 2'd0,
    ModeWrOne  = 2'd1,
    ModeWrTwo  = 2'd2,
    ModeNop    = 2'd3
  } item_mode_e;

  typedef enum logic [1:0] {
    ModBothFm = 2'd0,
    ModBothPm = 2'd1,
    ModMixed  = 2'd2,
    ModSpare  = 2'd3
  } mod_mode_e;

  typedef enum logic [4:0] {
    StIdle, StM2, StM1, StF1, StF2, StW1L, StW1H, StW2L, StW2H,
    StO1L, StO1H, StO2L, StO2H, StX1, StX2, StRa, StRb, StRc,
    StD1, StD2, StD3
  } state_e;

  function automatic logic [LenW-1:0] clamp_len(logic [LenW-1:0] v, int unsigned tmax);
    logic [LenW-1:0] r;
    if (v == '0) begin
      r = LenW'(1);
    end else if (32'(v) > tmax) begin
      r = LenW'(tmax);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/cmop_if.sv =====
`timescale 1ns / 1ps
// channel interfaces for the oscillator pair: sample items in, signal pairs out
// no dependencies
interface cmop_in_if #(parameter int unsigned SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    mode;
  logic [23:0]                   ratio_one;
  logic [23:0]                   ratio_two;
  logic signed [23:0]            depth_one;
  logic signed [23:0]            depth_two;
  logic [12:0]                   table_addr;
  logic signed [SAMPLE_BITS-1:0] table_data;

  modport source (output valid, mode, ratio_one, ratio_two, depth_one, depth_two,
                  table_addr, table_data, input ready);
  modport sink (input valid, mode, ratio_one, ratio_two, depth_one, depth_two,
                table_addr, table_data, output ready);
endinterface

interface cmop_out_if #(parameter int unsigned SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_one;
  logic signed [SAMPLE_BITS-1:0] out_two;

  modport source (output valid, out_one, out_two, input ready);
  modport sink (input valid, out_one, out_two, output ready);
endinterface

// ===== rtl/core/cross_modulated_oscillator_pair.sv =====
`timescale 1ns / 1ps
// cross modulated wavetable oscillator pair, top level
// depends on cmop_pkg and the cmop_in_if / cmop_out_if interfaces
//
// usage:
//  in_if carries items: mode 0 computes a sample, modes 1 and 2 write an entry of
//  wavetable one or two, mode 3 is dropped. out_if carries one signal pair per
//  sample item: the pair held before that item, loaded into the output register
//  in the cycle of the transfer, so it is visible in the cycle after acceptance.
//  a sample item then occupies the core, and no new item is taken until it is
//  finished: the phase, modulation and lookup arithmetic runs as 16 products
//  through one shared registered multiplier, interleaved with two reads of each
//  wavetable memory (entry and neighbour for interpolation). table writes and
//  dropped items do not occupy the core.
//  a new sample item is taken while the output register still holds a pair only
//  if that pair is transferred in the same cycle; a stalled receiver holds off
//  the input. the config port writes mod_mode, interpolate, base_increment and
//  the two table lengths, and must be used only while the block is idle; the
//  block itself does not enforce this. reset clears phases, held signals and
//  config; wavetable contents are undefined until written.
module cross_modulated_oscillator_pair
  import cmop_pkg::*;
#(
  parameter int unsigned TABLE_MAX   = TableMaxDef,
  parameter int unsigned SAMPLE_BITS = SampleBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  cmop_in_if.sink             in_if,
  cmop_out_if.source          out_if,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned AW = $clog2(TABLE_MAX + 1);
  localparam int unsigned MB = ((SB > 24) ? SB : 24) + 1;
  localparam int unsigned PW = MulAW + MB;
  localparam logic [LenW-1:0] LenRst = clamp_len(LenW'(4096), TABLE_MAX);

  // config
  logic [1:0]      mod_mode_q;
  logic            interp_q;
  logic [31:0]     base_inc_q;
  logic [LenW-1:0] len1_q, len2_q;

  // state
  state_e state_q, state_d;
  logic [31:0]          ph1_q, ph2_q;
  logic signed [SB-1:0] s1_q, s2_q;
  logic                 out_valid_q;
  logic signed [SB-1:0] out_one_q, out_two_q;

  // item and work registers
  logic [23:0]             r1_q, r2_q;
  logic signed [23:0]      d1_q, d2_q;
  logic signed [24:0]      m1_q, m2_q;
  logic signed [MulAW-1:0] w1_q, w2_q;
  logic signed [PW-1:0]    p_q, lo_q;
  logic [31:0]             look1_q, look2_q;
  logic [AW-1:0]           n1_q, n2_q;
  logic [15:0]             g1_q, g2_q;
  logic signed [SB-1:0]    y1_q, y2_q;
  logic signed [SB:0]      diff2_q;

  // memories
  logic signed [SB-1:0] wave_one [TABLE_MAX+1];
  logic signed [SB-1:0] wave_two [TABLE_MAX+1];
  logic signed [SB-1:0] rd1_q, rd2_q;
  logic [AW-1:0]        ra1, ra2;

  logic signed [MulAW-1:0] mul_a;
  logic signed [MB-1:0]    mul_b;

  logic in_acc, smp_acc, wr_ok, fm1, fm2;
  logic [31:0] wide_sum;
  logic signed [32:0] fpart;
  logic signed [SB:0] diff1;

  assign in_acc  = in_if.valid && in_if.ready;
  assign smp_acc = in_acc && (in_if.mode == ModeSample);
  assign wr_ok   = 32'(in_if.table_addr) <= TABLE_MAX;
  assign fm1     = mod_mode_q != ModBothPm;
  assign fm2     = (mod_mode_q != ModBothPm) && (mod_mode_q != ModMixed);

  assign in_if.ready    = (state_q == StIdle) && (!out_valid_q || out_if.ready);
  assign out_if.valid   = out_valid_q;
  assign out_if.out_one = out_one_q;
  assign out_if.out_two = out_two_q;

  assign wide_sum = lo_q[47:16] + p_q[31:0];
  assign fpart    = $signed(p_q[48:16]);
  assign diff1    = (SB+1)'(rd1_q) - (SB+1)'(y1_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (smp_acc) state_d = StM2;
      StM2:    state_d = StM1;
      StM1:    state_d = StF1;
      StF1:    state_d = StF2;
      StF2:    state_d = StW1L;
      StW1L:   state_d = StW1H;
      StW1H:   state_d = StW2L;
      StW2L:   state_d = StW2H;
      StW2H:   state_d = StO1L;
      StO1L:   state_d = StO1H;
      StO1H:   state_d = StO2L;
      StO2L:   state_d = StO2H;
      StO2H:   state_d = StX1;
      StX1:    state_d = StX2;
      StX2:    state_d = StRa;
      StRa:    state_d = StRb;
      StRb:    state_d = StRc;
      StRc:    state_d = StD1;
      StD1:    state_d = StD2;
      StD2:    state_d = StD3;
      StD3:    state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // multiplier operands and read addresses
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    ra1   = n1_q;
    ra2   = n2_q;
    unique case (state_q)
      StM2:  begin mul_a = MulAW'(d2_q); mul_b = MB'(s2_q); end
      StM1:  begin mul_a = MulAW'(d1_q); mul_b = MB'(s1_q); end
      StF1:  begin mul_a = MulAW'(r2_q); mul_b = MB'(m2_q); end
      StF2:  begin mul_a = MulAW'(r1_q); mul_b = MB'(m1_q); end
      StW1L: begin mul_a = w1_q; mul_b = MB'(base_inc_q[15:0]); end
      StW1H: begin mul_a = w1_q; mul_b = MB'(base_inc_q[31:16]); end
      StW2L: begin mul_a = w2_q; mul_b = MB'(base_inc_q[15:0]); end
      StW2H: begin mul_a = w2_q; mul_b = MB'(base_inc_q[31:16]); end
      StO1L: begin mul_a = MulAW'(m2_q); mul_b = MB'(InvTwoPi[15:0]); end
      StO1H: begin mul_a = MulAW'(m2_q); mul_b = MB'(InvTwoPi[31:16]); end
      StO2L: begin mul_a = MulAW'(m1_q); mul_b = MB'(InvTwoPi[15:0]); end
      StO2H: begin mul_a = MulAW'(m1_q); mul_b = MB'(InvTwoPi[31:16]); end
      StX1:  begin mul_a = MulAW'(look1_q); mul_b = MB'(len1_q); end
      StX2:  begin mul_a = MulAW'(look2_q); mul_b = MB'(len2_q); end
      StRc:  begin ra1 = AW'(n1_q + AW'(1)); ra2 = AW'(n2_q + AW'(1)); end
      StD1:  begin mul_a = MulAW'(diff1); mul_b = MB'(g1_q); end
      StD2:  begin mul_a = MulAW'(diff2_q); mul_b = MB'(g2_q); end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;
  end

  // wavetable memories
  always_ff @(posedge clk_i) begin
    if (in_acc && (in_if.mode == ModeWrOne) && wr_ok) begin
      wave_one[AW'(in_if.table_addr)] <= in_if.table_data;
    end
    rd1_q <= wave_one[ra1];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (in_if.mode == ModeWrTwo) && wr_ok) begin
      wave_two[AW'(in_if.table_addr)] <= in_if.table_data;
    end
    rd2_q <= wave_two[ra2];
  end

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_mode_q <= ModBothFm;
      interp_q   <= 1'b0;
      base_inc_q <= '0;
      len1_q     <= LenRst;
      len2_q     <= LenRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgModMode: mod_mode_q <= cfg_data_i[1:0];
        CfgInterp:  interp_q   <= cfg_data_i[0];
        CfgBaseInc: base_inc_q <= cfg_data_i;
        CfgLenOne:  len1_q     <= clamp_len(cfg_data_i[LenW-1:0], TABLE_MAX);
        CfgLenTwo:  len2_q     <= clamp_len(cfg_data_i[LenW-1:0], TABLE_MAX);
        default: ;
      endcase
    end
  end

  // control and oscillator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      ph1_q       <= '0;
      ph2_q       <= '0;
      s1_q        <= '0;
      s2_q        <= '0;
    end else begin
      state_q <= state_d;
      if (smp_acc) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StW2L: ph1_q <= ph1_q + wide_sum;
        StO1L: ph2_q <= ph2_q + wide_sum;
        StD2:  s1_q  <= interp_q ? SB'(y1_q + p_q[16 +: SB]) : y1_q;
        StD3:  s2_q  <= interp_q ? SB'(y2_q + p_q[16 +: SB]) : y2_q;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (smp_acc) begin
      out_one_q <= s1_q;
      out_two_q <= s2_q;
      r1_q      <= in_if.ratio_one;
      r2_q      <= in_if.ratio_two;
      d1_q      <= in_if.depth_one;
      d2_q      <= in_if.depth_two;
    end
    case (state_q)
      StM1:  m2_q <= $signed(p_q[SB-1 +: 25]);
      StF1:  m1_q <= $signed(p_q[SB-1 +: 25]);
      StF2:  w1_q <= MulAW'(r1_q) + (fm1 ? MulAW'(fpart) : MulAW'(0));
      StW1L: w2_q <= MulAW'(r2_q) + (fm2 ? MulAW'(fpart) : MulAW'(0));
      StW1H, StW2H, StO1H, StO2H: lo_q <= p_q;
      StO2L: look1_q <= ph1_q + (fm1 ? 32'd0 : wide_sum);
      StX1:  look2_q <= ph2_q + (fm2 ? 32'd0 : wide_sum);
      StX2:  begin n1_q <= p_q[32 +: AW]; g1_q <= p_q[31:16]; end
      StRa:  begin n2_q <= p_q[32 +: AW]; g2_q <= p_q[31:16]; end
      StRc:  begin y1_q <= rd1_q; y2_q <= rd2_q; end
      StD1:  diff2_q <= (SB+1)'(rd2_q) - (SB+1)'(y2_q);
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_if.ready)
    else $error("input ready while a sample is in progress");

  a_valid_from_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_if.valid) |-> $past(in_if.valid && in_if.ready && in_if.mode == ModeSample))
    else $error("output pair appeared without a sample transfer");

  a_sample_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready && in_if.mode == ModeSample) |=> (state_q == StM2))
    else $error("sample transfer did not start the sequence");
`endif

endmodule
